// ----- design/plg_pkg.sv -----
// ----------------------------------------------------------------------------
// plg_pkg
// shared types, constants and helpers of the peer link loss guard
// ----------------------------------------------------------------------------
package plg_pkg;

   // peer table geometry
   localparam int MAX_PEERS = 16;
   localparam int PEER_AW   = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int PEER_CW   = $clog2(MAX_PEERS + 1);

   // field widths
   localparam int ID_W   = 8;
   localparam int POS_W  = 32;
   localparam int TIM_W  = 32;
   localparam int DT_W   = 18;
   localparam int CONF_W = 24;
   localparam int PC_W   = 5;
   localparam int SLOT_W = 4;

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 144;
   localparam int CSR_AW     = 2;

   // step time limits
   localparam logic [DT_W-1:0] DT_DEFAULT = 18'd10000;
   localparam logic [DT_W-1:0] DT_MAX     = 18'd200000;

   // confirm time reset value
   localparam logic [CONF_W-1:0] CONFIRM_RST = 24'd300000;

   // item kinds on req_tuser
   localparam logic OP_SLOT_WRITE = 1'b0;
   localparam logic OP_TICK       = 1'b1;

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_GUARD_ENABLED   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_CLEAR_CONFIRM   = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_RECOVERY_CONFIRM = 2'd2;

   typedef enum logic [1:0] {
      GS_CLEAR   = 2'd0,
      GS_MONITOR = 2'd1,
      GS_HOLD    = 2'd2,
      GS_RECOVER = 2'd3
   } guard_state_type;

   // saturating timer advance
   function automatic logic [TIM_W-1:0] sat_add(input logic [TIM_W-1:0] a,
                                                input logic [DT_W-1:0]  b);
      logic [TIM_W:0] s;
      s = {1'b0, a} + (TIM_W+1)'(b);
      return s[TIM_W] ? {TIM_W{1'b1}} : s[TIM_W-1:0];
   endfunction

endpackage

// ----- design/peer_link_loss_guard_fsm.sv -----
// ----------------------------------------------------------------------------
// peer_link_loss_guard_fsm
// four-state guard that holds position when a hazard peer leaves the table
// ----------------------------------------------------------------------------
// a slot write item is written to the peer table; a tick item is scanned over
//   n = min(peer_count, MAX_PEERS) table entries, then evaluated and committed
//   to the output register; no new item is taken until the last tick commits;
//   the scan of the peer table ram reads one entry per cycle; output stalls delay the commit
// reset: synchronous active high; guard clear, timers and hold position zero,
//   all peer slots invalid, registers at their defaults
// ----------------------------------------------------------------------------
module peer_link_loss_guard_fsm (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // slot_index, slot_valid, slot_agent_id, peer_count, conflict,
   // conflict_agent_id, pos_x, pos_y, pos_z, step_dt_us, data_missing, zero fill
   input  logic [plg_pkg::REQ_DATA_W-1:0]    req_tdata,
   // opcode
   input  logic                              req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // guard_state, hold_x, hold_y, hold_z, time_in_state_us, hazard_id,
   // guard_active, hazard_peer_present, guard_moved, zero fill
   output logic [plg_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // configuration port
   input  logic                              csr_we,
   input  logic [plg_pkg::CSR_AW-1:0]        csr_addr,
   input  logic [plg_pkg::CONF_W-1:0]        csr_wdata
);

   import plg_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EVAL
   } seq_type;

   // request field unpacking
   logic [SLOT_W-1:0] req_slot;
   logic              req_slot_valid;
   logic [ID_W-1:0]   req_slot_id;
   logic [PC_W-1:0]   req_peer_count;
   logic              req_conflict;
   logic [ID_W-1:0]   req_conflict_id;
   logic [POS_W-1:0]  req_pos_x;
   logic [POS_W-1:0]  req_pos_y;
   logic [POS_W-1:0]  req_pos_z;
   logic [DT_W-1:0]   req_dt;
   logic              req_missing;

   assign req_slot        = req_tdata[3:0];
   assign req_slot_valid  = req_tdata[4];
   assign req_slot_id     = req_tdata[12:5];
   assign req_peer_count  = req_tdata[17:13];
   assign req_conflict    = req_tdata[18];
   assign req_conflict_id = req_tdata[26:19];
   assign req_pos_x       = req_tdata[58:27];
   assign req_pos_y       = req_tdata[90:59];
   assign req_pos_z       = req_tdata[122:91];
   assign req_dt          = req_tdata[140:123];
   assign req_missing     = req_tdata[141];

   // sequencer and handshake
   seq_type seq_ff;
   logic    req_fire;
   logic    slot_wr;
   logic    tick_fire;
   logic    out_free;

   assign req_tready = (seq_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign slot_wr    = req_fire && (req_tuser == OP_SLOT_WRITE) &&
                       (32'(req_slot) < MAX_PEERS);
   assign tick_fire  = req_fire && (req_tuser == OP_TICK);
   assign out_free   = !rsp_tvalid || rsp_tready;

   // configuration registers
   logic              enabled_ff;
   logic [CONF_W-1:0] clear_cf_ff;
   logic [CONF_W-1:0] recov_cf_ff;

   // guard state
   guard_state_type   mode_ff,  mode_in;
   logic [ID_W-1:0]   haz_ff,   haz_in;
   logic [TIM_W-1:0]  mt_ff,    mt_in;
   logic [TIM_W-1:0]  ct_ff,    ct_in;
   logic [TIM_W-1:0]  rt_ff,    rt_in;
   logic [POS_W-1:0]  hx_ff,    hx_in;
   logic [POS_W-1:0]  hy_ff,    hy_in;
   logic [POS_W-1:0]  hz_ff,    hz_in;
   logic              present_in;

   // captured tick
   logic [PEER_CW-1:0] n_ff;
   logic               conf_ff;
   logic [ID_W-1:0]    cid_ff;
   logic [POS_W-1:0]   px_ff;
   logic [POS_W-1:0]   py_ff;
   logic [POS_W-1:0]   pz_ff;
   logic [DT_W-1:0]    dt_ff;
   logic               miss_ff;

   // scan pipeline
   logic [MAX_PEERS-1:0] vld_ff;
   logic [PEER_CW-1:0]   rd_cnt_ff;
   logic                 rd_pend_ff;
   logic                 rd_vbit_ff;
   logic                 hit_old_ff;
   logic                 hit_cid_ff;
   logic                 rd_issue;
   logic [PEER_AW-1:0]   rd_addr;
   logic [ID_W-1:0]      rd_id;
   logic [PEER_CW-1:0]   n_in;
   logic [DT_W-1:0]      dt_in;

   logic [RSP_DATA_W-1:0] rsp_tdata_in;

   assign rd_issue = (seq_ff == S_SCAN) && (rd_cnt_ff < n_ff);
   assign rd_addr  = PEER_AW'(rd_cnt_ff);

   // scan covers only the slots named by the tick, capped at the table size
   assign n_in  = (32'(req_peer_count) > MAX_PEERS) ? PEER_CW'(MAX_PEERS)
                                                    : PEER_CW'(req_peer_count);
   // zero or out of range step time falls back to the default
   assign dt_in = ((req_dt == '0) || (req_dt > DT_MAX)) ? DT_DEFAULT : req_dt;

   // peer id store; valid marks live in flops so reset clears them at once
   plg_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_PEERS)
   ) u_peer_ram (
      .clock   (clock),
      .wr_en   (slot_wr),
      .wr_addr (PEER_AW'(req_slot)),
      .wr_data (req_slot_id),
      .rd_addr (rd_addr),
      .rd_data (rd_id)
   );

   // guard transition, evaluated once the scan has both presence answers
   always_comb begin
      logic pres_pre;
      logic same;
      logic [TIM_W-1:0] tsum;

      mode_in = mode_ff;
      haz_in  = haz_ff;
      mt_in   = mt_ff;
      ct_in   = ct_ff;
      rt_in   = rt_ff;
      hx_in   = hx_ff;
      hy_in   = hy_ff;
      hz_in   = hz_ff;
      present_in = 1'b0;
      tsum    = '0;

      // id zero never counts as present
      pres_pre = (haz_ff != '0) && hit_old_ff;
      same     = (haz_ff == cid_ff);

      if (!enabled_ff || miss_ff) begin
         // forced clear, hold position kept, mode timer not advanced
         mode_in = GS_CLEAR;
         if (mode_ff != GS_CLEAR) begin
            mt_in = '0;
         end
         haz_in = '0;
         ct_in  = '0;
         rt_in  = '0;
      end else begin
         mt_in = sat_add(mt_ff, dt_ff);
         if (conf_ff && (cid_ff != '0) &&
             !(((mode_ff == GS_HOLD) || (mode_ff == GS_RECOVER)) && !same)) begin
            if (!same || (mode_ff == GS_CLEAR) || (mode_ff == GS_MONITOR)) begin
               // start or restart monitoring the reported peer
               haz_in  = cid_ff;
               ct_in   = '0;
               rt_in   = '0;
               mode_in = GS_MONITOR;
               if ((mode_ff != GS_MONITOR) || !same) begin
                  mt_in = '0;
               end
            end else if (mode_ff == GS_HOLD) begin
               rt_in   = '0;
               mode_in = GS_RECOVER;
               mt_in   = '0;
            end else begin
               // recovering with the same peer still in conflict
               tsum  = sat_add(rt_ff, dt_ff);
               rt_in = tsum;
               if (tsum >= TIM_W'(recov_cf_ff)) begin
                  ct_in   = '0;
                  rt_in   = '0;
                  mode_in = GS_MONITOR;
                  mt_in   = '0;
               end
            end
         end else begin
            case (mode_ff)
               GS_MONITOR: begin
                  if (!pres_pre) begin
                     // peer lost: capture own position and hold
                     hx_in   = px_ff;
                     hy_in   = py_ff;
                     hz_in   = pz_ff;
                     ct_in   = '0;
                     rt_in   = '0;
                     mode_in = GS_HOLD;
                     mt_in   = '0;
                  end else begin
                     tsum  = sat_add(ct_ff, dt_ff);
                     ct_in = tsum;
                     if (tsum >= TIM_W'(clear_cf_ff)) begin
                        mode_in = GS_CLEAR;
                        mt_in   = '0;
                        haz_in  = '0;
                        ct_in   = '0;
                        rt_in   = '0;
                     end
                  end
               end
               GS_HOLD: begin
                  if (pres_pre) begin
                     rt_in   = '0;
                     mode_in = GS_RECOVER;
                     mt_in   = '0;
                  end
               end
               GS_RECOVER: begin
                  if (!pres_pre) begin
                     // peer lost again: hold at the old capture
                     ct_in   = '0;
                     rt_in   = '0;
                     mode_in = GS_HOLD;
                     mt_in   = '0;
                  end else begin
                     tsum  = sat_add(rt_ff, dt_ff);
                     rt_in = tsum;
                     if (tsum >= TIM_W'(recov_cf_ff)) begin
                        mode_in = GS_CLEAR;
                        mt_in   = '0;
                        haz_in  = '0;
                        ct_in   = '0;
                        rt_in   = '0;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         // presence after the step: the new hazard is zero, the old one or the reported one
         if (haz_in == '0) begin
            present_in = 1'b0;
         end else if (haz_in == haz_ff) begin
            present_in = hit_old_ff;
         end else begin
            present_in = hit_cid_ff;
         end
      end
   end

   assign rsp_tdata_in = {3'b000,
                          (mode_in != mode_ff),
                          present_in,
                          ((mode_in == GS_HOLD) || (mode_in == GS_RECOVER)),
                          haz_in,
                          mt_in,
                          hz_in,
                          hy_in,
                          hx_in,
                          mode_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff      <= S_IDLE;
         enabled_ff  <= 1'b0;
         clear_cf_ff <= CONFIRM_RST;
         recov_cf_ff <= CONFIRM_RST;
         mode_ff     <= GS_CLEAR;
         haz_ff      <= '0;
         mt_ff       <= '0;
         ct_ff       <= '0;
         rt_ff       <= '0;
         hx_ff       <= '0;
         hy_ff       <= '0;
         hz_ff       <= '0;
         vld_ff      <= '0;
         rd_cnt_ff   <= '0;
         rd_pend_ff  <= 1'b0;
         hit_old_ff  <= 1'b0;
         hit_cid_ff  <= 1'b0;
         rsp_tvalid  <= 1'b0;
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_addr)
               CSR_GUARD_ENABLED:    enabled_ff  <= csr_wdata[0];
               CSR_CLEAR_CONFIRM:    clear_cf_ff <= csr_wdata;
               CSR_RECOVERY_CONFIRM: recov_cf_ff <= csr_wdata;
               default: begin
               end
            endcase
         end

         // in the commit cycle the leaving item is replaced by the new one
         if (rsp_tvalid && rsp_tready && (seq_ff != S_EVAL)) begin
            rsp_tvalid <= 1'b0;
         end

         if (slot_wr) begin
            vld_ff[PEER_AW'(req_slot)] <= req_slot_valid;
         end

         // one table entry read per cycle, compared in the following cycle
         rd_pend_ff <= rd_issue;
         rd_vbit_ff <= vld_ff[rd_addr];
         if (rd_issue) begin
            rd_cnt_ff <= rd_cnt_ff + PEER_CW'(1);
         end
         if (rd_pend_ff && rd_vbit_ff) begin
            if (rd_id == haz_ff) begin
               hit_old_ff <= 1'b1;
            end
            if (rd_id == cid_ff) begin
               hit_cid_ff <= 1'b1;
            end
         end

         case (seq_ff)
            S_IDLE: begin
               if (tick_fire) begin
                  seq_ff     <= S_SCAN;
                  rd_cnt_ff  <= '0;
                  hit_old_ff <= 1'b0;
                  hit_cid_ff <= 1'b0;
                  n_ff       <= n_in;
                  conf_ff    <= req_conflict;
                  cid_ff     <= req_conflict_id;
                  px_ff      <= req_pos_x;
                  py_ff      <= req_pos_y;
                  pz_ff      <= req_pos_z;
                  dt_ff      <= dt_in;
                  miss_ff    <= req_missing;
               end
            end
            S_SCAN: begin
               if (!rd_issue && !rd_pend_ff) begin
                  seq_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               // commit only when the output register can take the item
               if (out_free) begin
                  seq_ff     <= S_IDLE;
                  mode_ff    <= mode_in;
                  haz_ff     <= haz_in;
                  mt_ff      <= mt_in;
                  ct_ff      <= ct_in;
                  rt_ff      <= rt_in;
                  hx_ff      <= hx_in;
                  hy_ff      <= hy_in;
                  hz_ff      <= hz_in;
                  rsp_tvalid <= 1'b1;
                  rsp_tdata  <= rsp_tdata_in;
               end
            end
            default: begin
               seq_ff <= S_IDLE;
            end
         endcase
      end
   end

   // clear always carries no hazard peer
   a_clear_no_hazard: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == GS_CLEAR) |-> (haz_ff == '0))
      else $error("guard clear with nonzero hazard id");

   // monitoring always names a real peer
   a_monitor_has_peer: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == GS_MONITOR) |-> (haz_ff != '0))
      else $error("guard monitoring without hazard id");

   // a state change restarts the time in state
   a_change_zeroes_timer: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[140]) |-> (rsp_tdata[129:98] == '0))
      else $error("state changed but time in state not zero");

   // the scan never reads past the slots in use
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == S_SCAN) |-> (rd_cnt_ff <= n_ff))
      else $error("peer scan ran past its count");

   // the guard state only moves when a tick result is committed
   a_state_on_commit: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != $past(mode_ff)) |-> $rose(rsp_tvalid) || ($past(rsp_tvalid) && rsp_tvalid))
      else $error("guard state moved without a result");

endmodule

// ----- design/plg_ram.sv -----
// ----------------------------------------------------------------------------
// plg_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module plg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
